@@ hw/rtl/lncs_pkg.sv @@
// lncs_pkg: shared types and constants for the lcd nibble command sequencer
// request, result, configuration and queue entry types; no dependencies
package lncs_pkg;

	typedef struct packed {
		logic [2:0]  operation;
		logic [7:0]  byte_value;
		logic [5:0]  column;
		logic [2:0]  row;
		logic [2:0]  glyph_slot;
		logic [63:0] glyph_pattern;
	} req_t;

	typedef struct packed {
		logic        register_select;
		logic        strobe_res;
		logic [3:0]  nibble;
		logic [19:0] wait_after_us;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [6:0]  line3_base;
		logic [6:0]  line4_base;
		logic [15:0] command_wait_us;
		logic [15:0] data_wait_us;
		logic [15:0] clear_wait_us;
		logic [15:0] home_wait_us;
		logic [19:0] bootup_wait_us;
		logic [15:0] reset_wait_us;
	} cfg_t;

	localparam int CFG_DATA_W  = 20;
	localparam int CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_LINE3_BASE   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LINE4_BASE   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_WAIT = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_DATA_WAIT    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_WAIT   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_HOME_WAIT    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_BOOTUP_WAIT  = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_RESET_WAIT   = 3'd7;

	localparam cfg_t CFG_RESET = '{
		line3_base:      7'd16,
		line4_base:      7'd80,
		command_wait_us: 16'd42,
		data_wait_us:    16'd46,
		clear_wait_us:   16'd2000,
		home_wait_us:    16'd2000,
		bootup_wait_us:  20'd15000,
		reset_wait_us:   16'd5000
	};

	localparam logic [2:0] OP_DATA       = 3'd0;
	localparam logic [2:0] OP_COMMAND    = 3'd1;
	localparam logic [2:0] OP_SET_CURSOR = 3'd2;
	localparam logic [2:0] OP_CLEAR      = 3'd3;
	localparam logic [2:0] OP_HOME       = 3'd4;
	localparam logic [2:0] OP_INIT       = 3'd5;
	localparam logic [2:0] OP_GLYPH      = 3'd6;

	localparam logic [7:0] CMD_CLEAR        = 8'h01;
	localparam logic [7:0] CMD_HOME         = 8'h02;
	localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
	localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
	localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
	localparam logic [6:0] LINE1_BASE       = 7'h00;
	localparam logic [6:0] LINE2_BASE       = 7'h40;
	localparam logic [3:0] NIB_SOFT_RESET   = 4'h3;
	localparam logic [3:0] NIB_FOUR_BIT     = 4'h2;

	typedef enum logic [2:0] {
		KIND_DATA,
		KIND_CMD,
		KIND_CLEAR,
		KIND_HOME,
		KIND_INIT,
		KIND_GLYPH
	} kind_t;

	typedef logic [4:0] step_t;

	localparam step_t LAST_STEP_BYTE  = 5'd1;
	localparam step_t LAST_STEP_INIT  = 5'd12;
	localparam step_t LAST_STEP_GLYPH = 5'd17;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  cmd_byte;
		logic [63:0] glyph_pattern;
	} entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

@@ hw/rtl/lncs_front.sv @@
// lncs_front: classifies a request into a queue entry
// depends on lncs_pkg; computes cursor and glyph command bytes
module lncs_front import lncs_pkg::*; (
	input  req_t       request,
	input  logic [6:0] line3_base,
	input  logic [6:0] line4_base,
	output entry_t     entry,
	output logic       keep
);

	logic [6:0] base_c;
	logic [6:0] addr_c;

	always_comb begin
		case (request.row)
			3'd0:    base_c = LINE1_BASE;
			3'd1:    base_c = LINE2_BASE;
			3'd2:    base_c = line3_base;
			default: base_c = line4_base;
		endcase
	end

	assign addr_c = base_c + {1'b0, request.column};

	always_comb begin
		entry.glyph_pattern = request.glyph_pattern;
		entry.cmd_byte      = request.byte_value;
		entry.kind          = KIND_CMD;
		keep                = 1'b1;
		case (request.operation)
			OP_DATA: begin
				entry.kind = KIND_DATA;
			end
			OP_COMMAND: begin
				entry.kind = KIND_CMD;
			end
			OP_SET_CURSOR: begin
				entry.kind     = KIND_CMD;
				entry.cmd_byte = {1'b1, addr_c};
				keep           = ~request.row[2];
			end
			OP_CLEAR: begin
				entry.kind = KIND_CLEAR;
			end
			OP_HOME: begin
				entry.kind = KIND_HOME;
			end
			OP_INIT: begin
				entry.kind = KIND_INIT;
			end
			OP_GLYPH: begin
				entry.kind     = KIND_GLYPH;
				entry.cmd_byte = {2'b01, request.glyph_slot, 3'b000};
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

endmodule

@@ hw/rtl/lncs_queue.sv @@
// lncs_queue: short fifo of classified entries between front and back
// depends on lncs_pkg for entry and status types
module lncs_queue import lncs_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  entry_t    push_entry,
	input  logic      pop,
	output entry_t    head,
	output q_status_t status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		logic [PW-1:0] n;
		if (p == PW'(DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + PW'(1);
		end
		return n;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign head         = mem_q[rd_ptr_q];
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == CW'(DEPTH));

endmodule

@@ hw/rtl/lncs_back.sv @@
// lncs_back: steps through the transfers of the head entry, one per cycle
// depends on lncs_pkg; reads wait registers from the configuration block
module lncs_back import lncs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  entry_t    head,
	input  q_status_t status,
	output logic      pop,
	output logic      result_valid,
	output res_t      result
);

	step_t       step_q;
	logic        result_valid_q;
	res_t        result_q;

	step_t       last_step_c;
	logic [7:0]  byte_c;
	logic        rs_c;
	logic        lo_c;
	logic        data_c;
	logic [15:0] extra_c;
	logic        raw_c;
	logic        raw_strobe_c;
	logic [3:0]  raw_nib_c;
	logic [19:0] raw_wait_c;
	logic [19:0] byte_wait_c;
	step_t       gstep_c;
	logic [2:0]  grow_c;
	res_t        xfer_c;
	logic        active_c;
	logic        final_c;

	assign gstep_c = step_q - 5'd2;
	assign grow_c  = gstep_c[3:1];

	always_comb begin
		last_step_c  = LAST_STEP_BYTE;
		byte_c       = head.cmd_byte;
		rs_c         = 1'b0;
		lo_c         = step_q[0];
		data_c       = 1'b0;
		extra_c      = '0;
		raw_c        = 1'b0;
		raw_strobe_c = 1'b1;
		raw_nib_c    = '0;
		raw_wait_c   = {4'b0, cfg.reset_wait_us};
		case (head.kind)
			KIND_DATA: begin
				rs_c   = 1'b1;
				data_c = 1'b1;
			end
			KIND_CLEAR: begin
				byte_c  = CMD_CLEAR;
				extra_c = cfg.clear_wait_us;
			end
			KIND_HOME: begin
				byte_c  = CMD_HOME;
				extra_c = cfg.home_wait_us;
			end
			KIND_INIT: begin
				last_step_c = LAST_STEP_INIT;
				lo_c        = ~step_q[0];
				case (step_q)
					5'd0: begin
						raw_c        = 1'b1;
						raw_strobe_c = 1'b0;
						raw_wait_c   = cfg.bootup_wait_us;
					end
					5'd1, 5'd2, 5'd3: begin
						raw_c     = 1'b1;
						raw_nib_c = NIB_SOFT_RESET;
					end
					5'd4: begin
						raw_c     = 1'b1;
						raw_nib_c = NIB_FOUR_BIT;
					end
					5'd5, 5'd6: byte_c = CMD_FUNCTION_SET;
					5'd7, 5'd8: byte_c = CMD_DISPLAY_ON;
					5'd9, 5'd10: byte_c = CMD_ENTRY_MODE;
					default: begin
						byte_c  = CMD_CLEAR;
						extra_c = cfg.clear_wait_us;
					end
				endcase
			end
			KIND_GLYPH: begin
				last_step_c = LAST_STEP_GLYPH;
				if (step_q > 5'd1) begin
					rs_c   = 1'b1;
					data_c = 1'b1;
					byte_c = head.glyph_pattern[grow_c*8 +: 8];
				end
			end
			default: begin
			end
		endcase
	end

	assign byte_wait_c = data_c ? {4'b0, cfg.data_wait_us}
		: ({4'b0, cfg.command_wait_us} + {4'b0, extra_c});

	always_comb begin
		xfer_c.register_select = rs_c;
		xfer_c.strobe_res      = raw_c ? raw_strobe_c : 1'b1;
		xfer_c.nibble          = raw_c ? raw_nib_c : (lo_c ? byte_c[3:0] : byte_c[7:4]);
		xfer_c.wait_after_us   = raw_c ? raw_wait_c : (lo_c ? byte_wait_c : '0);
		xfer_c.last            = (step_q == last_step_c);
	end

	assign active_c = ~status.empty;
	assign final_c  = active_c && (step_q == last_step_c);
	assign pop      = final_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= active_c;
			if (final_c) begin
				step_q <= '0;
			end else if (active_c) begin
				step_q <= step_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (active_c) begin
			result_q <= xfer_c;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

@@ hw/rtl/lcd_nibble_command_sequencer.sv @@
// lcd_nibble_command_sequencer: top level, configuration registers and wiring
// depends on lncs_pkg, lncs_front, lncs_queue and lncs_back
//
//   channel   signals                            transaction when
//   request   start, busy, request               start && !busy
//   result    result_valid, result               result_valid (one cycle)
//   config    cfg_we, cfg_index, cfg_data        cfg_we
//
// one transfer per cycle: a request steps through its byte, init or define glyph transfers
// in the back sequencer, whose step counter sets the rate
// results are registered and appear in the cycle after the step that builds them
// busy is high only while the entry queue is full
// asynchronous active-low reset restores the register defaults and empties the queue
// the receiver cannot stall; transfers of one request come in consecutive cycles
module lcd_nibble_command_sequencer import lncs_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  req_t                   request,
	output logic                   result_valid,
	output res_t                   result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t      cfg_q;
	entry_t    entry;
	logic      keep;
	logic      push;
	logic      pop;
	entry_t    head;
	q_status_t qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINE3_BASE:   cfg_q.line3_base      <= cfg_data[6:0];
				REG_LINE4_BASE:   cfg_q.line4_base      <= cfg_data[6:0];
				REG_COMMAND_WAIT: cfg_q.command_wait_us <= cfg_data[15:0];
				REG_DATA_WAIT:    cfg_q.data_wait_us    <= cfg_data[15:0];
				REG_CLEAR_WAIT:   cfg_q.clear_wait_us   <= cfg_data[15:0];
				REG_HOME_WAIT:    cfg_q.home_wait_us    <= cfg_data[15:0];
				REG_BOOTUP_WAIT:  cfg_q.bootup_wait_us  <= cfg_data[19:0];
				REG_RESET_WAIT:   cfg_q.reset_wait_us   <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	lncs_front u_front (
		.request    (request),
		.line3_base (cfg_q.line3_base),
		.line4_base (cfg_q.line4_base),
		.entry      (entry),
		.keep       (keep)
	);

	assign busy = qstat.full;
	assign push = start && !busy && keep;

	lncs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (entry),
		.pop        (pop),
		.head       (head),
		.status     (qstat)
	);

	lncs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.status       (qstat),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result)
	);

	// wait-only transfers drive the command register with a zero nibble
	a_wait_only_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.strobe_res |-> result.nibble == 4'h0 && !result.register_select)
		else $error("wait-only transfer drives data lines");

	// a request's transfers are never interrupted
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |=> result_valid)
		else $error("gap inside a request's transfers");

	// a full queue stays full until the back sequencer pops an entry
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full && !pop |=> qstat.full)
		else $error("queue left full state without a pop");

endmodule
